// ===== hdl/ecgf_pkg.sv =====
// Shared types and constants for the elevation cell fusion block.
// No dependencies; the other files except ecgf_ram refer to it by scoped names.
package ecgf_pkg;

	localparam int IDX_W      = 16;  // cell index field
	localparam int DATA_W     = 32;  // height and variance fields
	localparam int PROD_W     = 64;  // 32x32 product
	localparam int DEN_W      = 33;  // v + pv
	localparam int NUM_W      = 65;  // product plus half the denominator
	localparam int QUO_W      = 32;  // quotient width, bounded by min(v, pv) or |z-m|
	localparam int STEP_BITS  = 2;   // quotient bits per divider cycle
	localparam int DIV_STEPS  = QUO_W / STEP_BITS;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_MUL1,
		ST_MUL2,
		ST_LOAD,
		ST_DIV,
		ST_FIN
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;    // latch input fields, launch cell read
		logic look;      // cell contents available
		logic mul1;      // v * pv
		logic mul2;      // |z - m| * v
		logic div_load;  // load both divider lanes
		logic div_step;  // one divider step
		logic fin;       // write cell back, load output register
		logic clr_step;  // clear one valid bit
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic drop;      // input point off the map or beyond the grid
		logic skip;      // empty cell or zero denominator, no fusion needed
		logic clr_last;  // clear pass at the last cell
	} status_t;

endpackage

// ===== hdl/elevation_cell_gaussian_fuse_top.sv =====
// A point taken in IDLE passes LOOK, MUL1, MUL2, LOAD, DIV and FIN (an empty cell or
// zero denominator goes from LOOK to FIN; a dropped point stays in IDLE). FIN writes
// the cell back and loads the output register, waiting while a result still holds it.
// The pace is set by the divider, 2 quotient bits per cycle in two lanes.
// Reset (arst_n, async, active low) clears control state, then a clear pass writes
// every valid bit, one cell per cycle, with in_stall held high.
module elevation_cell_gaussian_fuse_top #(
	parameter int GRID_CELLS = 65536
) (
	input  logic                                clk,
	input  logic                                arst_n,

	// point input: one transfer per processed point
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ecgf_pkg::IDX_W-1:0]          cell_index,
	input  logic                                in_map,
	input  logic signed [ecgf_pkg::DATA_W-1:0]  point_height,
	input  logic [ecgf_pkg::DATA_W-1:0]         point_variance,

	// updated cell output: at most one transfer per point
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [ecgf_pkg::IDX_W-1:0]          out_index,
	output logic signed [ecgf_pkg::DATA_W-1:0]  fused_height,
	output logic [ecgf_pkg::DATA_W-1:0]         fused_variance,
	output logic                                first_hit
);

	// Top level of the elevation cell fusion block; depends on ecgf_pkg, ecgf_ctrl,
	// ecgf_dp.
	// Flow per point:
	//   IDLE   take the transfer, launch the cell read (points off the map or
	//          beyond the grid are taken and dropped here)
	//   LOOK   cell contents arrive; empty cell or v+pv==0 goes straight to FIN
	//   MUL1   v*pv                  (shared 32x32 multiplier)
	//   MUL2   |z-m|*v, add den/2 to v*pv
	//   LOAD   add den/2 to |z-m|*v, load both divider lanes
	//   DIV    mean and variance quotients in parallel
	//   FIN    write the cell back and load the output register once it is free
	// The output register lets the next point be taken while a result waits.
	// Rounding: both quotients are floor((p + den/2)/den); the mean step is
	// applied with the sign of z-m, which rounds halves away from zero.

	ecgf_pkg::cmd_t    cmd;
	ecgf_pkg::status_t st;

	ecgf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	ecgf_dp #(.GRID_CELLS(GRID_CELLS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.cell_index     (cell_index),
		.in_map         (in_map),
		.point_height   (point_height),
		.point_variance (point_variance),
		.out_index      (out_index),
		.fused_height   (fused_height),
		.fused_variance (fused_variance),
		.first_hit      (first_hit)
	);

endmodule

// ===== hdl/ecgf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ecgf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/ecgf_div.sv =====
// Restoring divider lane, two quotient bits per cycle while step is high, 32-bit quotient.
// Depends on ecgf_pkg. Caller guarantees num < den * 2^32.
module ecgf_div (
	input  logic                         clk,
	input  logic                         load,
	input  logic                         step,
	input  logic [ecgf_pkg::NUM_W-1:0]   num,
	input  logic [ecgf_pkg::DEN_W-1:0]   den,
	output logic [ecgf_pkg::QUO_W-1:0]   quo
);

	// partial remainder (upper) and numerator bits / quotient bits (lower)
	logic [ecgf_pkg::DEN_W-1:0] rem_q;
	logic [ecgf_pkg::QUO_W-1:0] lo_q;
	logic [ecgf_pkg::DEN_W-1:0] rem_nxt;
	logic [ecgf_pkg::QUO_W-1:0] lo_nxt;

	always_comb begin
		logic [ecgf_pkg::DEN_W:0] t;
		logic                     qbit;
		rem_nxt = rem_q;
		lo_nxt  = lo_q;
		for (int i = 0; i < ecgf_pkg::STEP_BITS; i++) begin
			t = {rem_nxt, lo_nxt[ecgf_pkg::QUO_W-1]};
			if (t >= {1'b0, den}) begin
				t    = t - {1'b0, den};
				qbit = 1'b1;
			end else begin
				qbit = 1'b0;
			end
			rem_nxt = t[ecgf_pkg::DEN_W-1:0];
			lo_nxt  = {lo_nxt[ecgf_pkg::QUO_W-2:0], qbit};
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= num[ecgf_pkg::NUM_W-1:ecgf_pkg::QUO_W];
			lo_q  <= num[ecgf_pkg::QUO_W-1:0];
		end else if (step) begin
			rem_q <= rem_nxt;
			lo_q  <= lo_nxt;
		end
	end

	assign quo = lo_q;

endmodule

// ===== hdl/ecgf_dp.sv =====
// Datapath: cell memories, clear counter, shared multiplier, two divider lanes,
// output register. Depends on ecgf_pkg, ecgf_ram and ecgf_div.
module ecgf_dp #(
	parameter int GRID_CELLS = 65536
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ecgf_pkg::cmd_t                      cmd,
	output ecgf_pkg::status_t                   st,
	input  logic [ecgf_pkg::IDX_W-1:0]          cell_index,
	input  logic                                in_map,
	input  logic signed [ecgf_pkg::DATA_W-1:0]  point_height,
	input  logic [ecgf_pkg::DATA_W-1:0]         point_variance,
	output logic [ecgf_pkg::IDX_W-1:0]          out_index,
	output logic signed [ecgf_pkg::DATA_W-1:0]  fused_height,
	output logic [ecgf_pkg::DATA_W-1:0]         fused_variance,
	output logic                                first_hit
);

	localparam int AW = $clog2(GRID_CELLS);
	localparam int DW = ecgf_pkg::DATA_W;

	// address decode
	logic [31:0]   idx_ext;
	logic [AW-1:0] rd_addr;

	assign idx_ext = {{(32 - ecgf_pkg::IDX_W){1'b0}}, cell_index};
	assign rd_addr = idx_ext[AW-1:0];

	// input latch
	logic [ecgf_pkg::IDX_W-1:0] idx_q;
	logic [AW-1:0]              addr_q;
	logic [DW-1:0]              z_q;
	logic [DW-1:0]              pv_q;

	// cell state and intermediates
	logic [DW-1:0]                  m_q, v_q;
	logic                           first_q, denz_q;
	logic [DW:0]                    diff_q;
	logic [ecgf_pkg::DEN_W-1:0]     den_q;
	logic [DW-1:0]                  mag_q;
	logic                           neg_q;
	logic [ecgf_pkg::PROD_W-1:0]    prod_q;
	logic [ecgf_pkg::NUM_W-1:0]     numv_q;
	logic [AW-1:0]                  clr_q;

	// output register
	logic [ecgf_pkg::IDX_W-1:0] out_index_q;
	logic [DW-1:0]              fused_height_q;
	logic [DW-1:0]              fused_variance_q;
	logic                       first_hit_q;

	// memories
	logic [2*DW-1:0] mv_rd, mv_wr;
	logic            vld_rd;
	logic            vld_we;
	logic [AW-1:0]   vld_waddr;

	assign vld_we    = cmd.clr_step | cmd.fin;
	assign vld_waddr = cmd.clr_step ? clr_q : addr_q;

	ecgf_ram #(.WIDTH(2 * DW), .DEPTH(GRID_CELLS)) u_mv_ram (
		.clk   (clk),
		.we    (cmd.fin),
		.waddr (addr_q),
		.wdata (mv_wr),
		.re    (cmd.accept),
		.raddr (rd_addr),
		.rdata (mv_rd)
	);

	ecgf_ram #(.WIDTH(1), .DEPTH(GRID_CELLS)) u_vld_ram (
		.clk   (clk),
		.we    (vld_we),
		.waddr (vld_waddr),
		.wdata (~cmd.clr_step),
		.re    (cmd.accept),
		.raddr (rd_addr),
		.rdata (vld_rd)
	);

	// status
	assign st.drop     = ~in_map | (idx_ext >= 32'(GRID_CELLS));
	assign st.skip     = ~vld_rd | ((mv_rd[DW-1:0] == '0) & (pv_q == '0));
	assign st.clr_last = (clr_q == AW'(GRID_CELLS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// shared multiplier: v*pv first, then |z-m|*v
	logic [DW-1:0]               mul_a, mul_b;
	logic [ecgf_pkg::PROD_W-1:0] mul_p;
	logic [ecgf_pkg::NUM_W-1:0]  half_den;
	logic [DW:0]                 mag_full;

	assign mul_a    = cmd.mul2 ? mag_q : v_q;
	assign mul_b    = cmd.mul2 ? v_q : pv_q;
	assign mul_p    = mul_a * mul_b;
	assign half_den = ecgf_pkg::NUM_W'(den_q[ecgf_pkg::DEN_W-1:1]);
	assign mag_full = diff_q[DW] ? (~diff_q + (DW+1)'(1)) : diff_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q  <= cell_index;
			addr_q <= rd_addr;
			z_q    <= point_height;
			pv_q   <= point_variance;
		end
		if (cmd.look) begin
			m_q     <= mv_rd[2*DW-1:DW];
			v_q     <= mv_rd[DW-1:0];
			first_q <= ~vld_rd;
			denz_q  <= (mv_rd[DW-1:0] == '0) & (pv_q == '0);
			diff_q  <= {z_q[DW-1], z_q} - {mv_rd[2*DW-1], mv_rd[2*DW-1:DW]};
			den_q   <= {1'b0, mv_rd[DW-1:0]} + {1'b0, pv_q};
		end
		if (cmd.mul1) begin
			prod_q <= mul_p;
			neg_q  <= diff_q[DW];
			mag_q  <= mag_full[DW-1:0];
		end
		if (cmd.mul2) begin
			prod_q <= mul_p;
			numv_q <= {1'b0, prod_q} + half_den;
		end
	end

	// divider lanes
	logic [ecgf_pkg::NUM_W-1:0] numm;
	logic [ecgf_pkg::QUO_W-1:0] qm, qv;

	assign numm = {1'b0, prod_q} + half_den;

	ecgf_div u_div_m (
		.clk  (clk),
		.load (cmd.div_load),
		.step (cmd.div_step),
		.num  (numm),
		.den  (den_q),
		.quo  (qm)
	);

	ecgf_div u_div_v (
		.clk  (clk),
		.load (cmd.div_load),
		.step (cmd.div_step),
		.num  (numv_q),
		.den  (den_q),
		.quo  (qv)
	);

	// new cell contents
	logic [DW:0]   sum_m;
	logic [DW-1:0] new_m, new_v;

	assign sum_m = neg_q ? ({m_q[DW-1], m_q} - {1'b0, qm}) : ({m_q[DW-1], m_q} + {1'b0, qm});

	always_comb begin
		priority if (first_q) begin
			new_m = z_q;
			new_v = pv_q;
		end else if (denz_q) begin
			new_m = m_q;
			new_v = v_q;
		end else begin
			new_m = sum_m[DW-1:0];
			new_v = qv;
		end
	end

	assign mv_wr = {new_m, new_v};

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_index_q      <= idx_q;
			fused_height_q   <= new_m;
			fused_variance_q <= new_v;
			first_hit_q      <= first_q;
		end
	end

	assign out_index      = out_index_q;
	assign fused_height   = fused_height_q;
	assign fused_variance = fused_variance_q;
	assign first_hit      = first_hit_q;

endmodule

// ===== hdl/ecgf_ctrl.sv =====
// Controller: sequences clear pass, cell lookup, multiply, divide and write-back;
// owns the input stall and output valid. Depends on ecgf_pkg.
module ecgf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  ecgf_pkg::status_t   st,
	output ecgf_pkg::cmd_t      cmd
);

	ecgf_pkg::state_t                 state_q, state_nxt;
	logic [ecgf_pkg::DIV_CNT_W-1:0]   div_cnt_q;
	logic                             out_valid_q;
	logic                             out_free;

	// output slot is free if empty or being taken at this edge
	assign out_free = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ecgf_pkg::ST_CLEAR;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			out_valid_q <= cmd.fin | (out_valid_q & out_stall);
			if (cmd.div_load) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + ecgf_pkg::DIV_CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		unique case (state_q)
			ecgf_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) begin
					state_nxt = ecgf_pkg::ST_IDLE;
				end
			end
			ecgf_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (!st.drop) begin
						state_nxt = ecgf_pkg::ST_LOOK;
					end
				end
			end
			ecgf_pkg::ST_LOOK: begin
				cmd.look  = 1'b1;
				state_nxt = st.skip ? ecgf_pkg::ST_FIN : ecgf_pkg::ST_MUL1;
			end
			ecgf_pkg::ST_MUL1: begin
				cmd.mul1  = 1'b1;
				state_nxt = ecgf_pkg::ST_MUL2;
			end
			ecgf_pkg::ST_MUL2: begin
				cmd.mul2  = 1'b1;
				state_nxt = ecgf_pkg::ST_LOAD;
			end
			ecgf_pkg::ST_LOAD: begin
				cmd.div_load = 1'b1;
				state_nxt    = ecgf_pkg::ST_DIV;
			end
			ecgf_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == ecgf_pkg::DIV_CNT_W'(ecgf_pkg::DIV_STEPS - 1)) begin
					state_nxt = ecgf_pkg::ST_FIN;
				end
			end
			ecgf_pkg::ST_FIN: begin
				if (out_free) begin
					cmd.fin   = 1'b1;
					state_nxt = ecgf_pkg::ST_IDLE;
				end
			end
		endcase
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	// a finished result never overwrites one that is still waiting
	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ecgf_pkg::ST_FIN && out_valid_q && out_stall) |=> state_q == ecgf_pkg::ST_FIN)
		else $error("result loaded over a stalled output");

	// output valid only rises from write-back
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ecgf_pkg::ST_FIN))
		else $error("output valid without write-back");

	// no transfer taken during the clear pass
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ecgf_pkg::ST_CLEAR |-> in_stall)
		else $error("input taken while clearing");

	// divider always starts from step zero
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ecgf_pkg::ST_LOAD |=> (state_q == ecgf_pkg::ST_DIV && div_cnt_q == '0))
		else $error("divider started mid-count");
`endif

endmodule
